// File: hdl/ase_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ase_pkg
// Types and constants used by the accelerometer emulator core.
// ----------------------------------------------------------------------------
package ase_pkg;

  // serial multiplier geometry
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 7;
  localparam int A_W        = 48;
  localparam int B_W        = DIGIT_W * NUM_DIGITS;
  localparam int ACC_W      = 68;
  localparam int BODY_W     = 40;

  // configuration register indexes
  localparam logic [2:0] REG_IMU_X    = 3'd0;
  localparam logic [2:0] REG_IMU_Y    = 3'd1;
  localparam logic [2:0] REG_IMU_Z    = 3'd2;
  localparam logic [2:0] REG_SENS     = 3'd3;
  localparam logic [2:0] REG_BIAS     = 3'd4;
  localparam logic [2:0] REG_DEV      = 3'd5;
  localparam logic [2:0] REG_RES      = 3'd6;
  localparam logic [2:0] REG_GRAVITY  = 3'd7;

  // micro-program steps
  localparam logic [4:0] OP_COL0A = 5'd0;
  localparam logic [4:0] OP_COL0B = 5'd1;
  localparam logic [4:0] OP_COL1A = 5'd2;
  localparam logic [4:0] OP_COL1B = 5'd3;
  localparam logic [4:0] OP_COL2A = 5'd4;
  localparam logic [4:0] OP_COL2B = 5'd5;
  localparam logic [4:0] OP_COL2C = 5'd6;
  localparam logic [4:0] OP_COL2D = 5'd7;
  localparam logic [4:0] OP_GRAV0 = 5'd8;
  localparam logic [4:0] OP_GRAV1 = 5'd9;
  localparam logic [4:0] OP_GRAV2 = 5'd10;
  localparam logic [4:0] OP_AXIS  = 5'd11;
  localparam logic [4:0] OP_LAST  = 5'd25;

  // phases within one axis
  localparam logic [2:0] PH_K0    = 3'd0;
  localparam logic [2:0] PH_K1    = 3'd1;
  localparam logic [2:0] PH_K2    = 3'd2;
  localparam logic [2:0] PH_NOISE = 3'd3;
  localparam logic [2:0] PH_FINAL = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_POST
  } state_t;

endpackage
`default_nettype wire

// File: hdl/ase_sample_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ase_sample_if
// Input item channel: timestamp, attitude, acceleration and noise.
// ----------------------------------------------------------------------------
interface ase_sample_if;
  logic               valid;
  logic               ready;
  logic        [31:0] time_now;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [31:0] accel_x;
  logic signed [31:0] accel_y;
  logic signed [31:0] accel_z;
  logic signed [15:0] noise_x;
  logic signed [15:0] noise_y;
  logic signed [15:0] noise_z;

  modport source (output valid, time_now, quat_w, quat_x, quat_y, quat_z,
                  accel_x, accel_y, accel_z, noise_x, noise_y, noise_z,
                  input ready);
  modport sink (input valid, time_now, quat_w, quat_x, quat_y, quat_z,
                accel_x, accel_y, accel_z, noise_x, noise_y, noise_z,
                output ready);
endinterface
`default_nettype wire

// File: hdl/ase_reading_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ase_reading_if
// Result item channel: three saturated readings in counts.
// ----------------------------------------------------------------------------
interface ase_reading_if;
  logic        valid;
  logic        ready;
  logic [15:0] reading_x;
  logic [15:0] reading_y;
  logic [15:0] reading_z;

  modport source (output valid, reading_x, reading_y, reading_z, input ready);
  modport sink (input valid, reading_x, reading_y, reading_z, output ready);
endinterface
`default_nettype wire

// File: hdl/accelerometer_sensor_emulator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// accelerometer_sensor_emulator_core
// Three-axis accelerometer emulator on one shared digit-serial multiplier.
// ----------------------------------------------------------------------------
// channel   dir  handshake      contents
// sample    in   valid/ready    time_now, quaternion, body accel, noise
// reading   out  valid/ready    reading_x/y/z counts
// cfg       in   cfg_we         cfg_index, cfg_data (48 bits)
//
// an early item is taken and gives nothing
// a due item runs 26 multiply steps (load, 7 digits of 4 bits, store)
// on the single serial multiplier
// the finished reading waits in an output register; the next item can be
// taken meanwhile, and each of its three reading stores waits until that
// register is free
// reset (rst, synchronous) restores the register defaults and next_due = 0
// ----------------------------------------------------------------------------
module accelerometer_sensor_emulator_core
  import ase_pkg::*;
#(
  parameter int unsigned PERIOD = 100
) (
  input  wire logic        clk,
  input  wire logic        rst,
  ase_sample_if.sink       sample,
  ase_reading_if.source    reading,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);

  // configuration
  logic        [47:0] imu_row [3];
  logic        [47:0] sens_packed;
  logic        [47:0] bias_packed;
  logic        [47:0] dev_packed;
  logic        [15:0] res;
  logic signed [31:0] gravity;

  always_ff @(posedge clk) begin
    if (rst) begin
      imu_row[0]  <= 48'h4000_0000_0000;
      imu_row[1]  <= 48'h0000_4000_0000;
      imu_row[2]  <= 48'h0000_0000_4000;
      sens_packed <= 48'h0100_0100_0100;
      bias_packed <= '0;
      dev_packed  <= '0;
      res         <= 16'hFFFF;
      gravity     <= 32'sd642908;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMU_X:   imu_row[0]  <= cfg_data;
        REG_IMU_Y:   imu_row[1]  <= cfg_data;
        REG_IMU_Z:   imu_row[2]  <= cfg_data;
        REG_SENS:    sens_packed <= cfg_data;
        REG_BIAS:    bias_packed <= cfg_data;
        REG_DEV:     dev_packed  <= cfg_data;
        REG_RES:     res         <= cfg_data[15:0];
        REG_GRAVITY: gravity     <= signed'(cfg_data[31:0]);
        default: ;
      endcase
    end
  end

  // control
  state_t state, state_next;
  logic [4:0]  op;
  logic [2:0]  dcnt;
  logic [31:0] next_due;
  logic        out_valid;
  logic        accept, due, last_op, store_op, post_fire;

  // captured item
  logic signed [15:0] q_w, q_x, q_y, q_z;
  logic signed [31:0] acc_in [3];
  logic signed [15:0] noise [3];

  // working values
  logic signed [B_W-1:0]    c20 [3];
  logic signed [BODY_W-1:0] body [3];
  logic signed [A_W-1:0]    imu;
  logic signed [A_W-1:0]    s_sum;
  logic        [15:0]       rd [3];

  // serial multiplier
  logic signed [ACC_W-1:0] acc, a_sh, pp, dig_ext;
  logic signed [B_W-1:0]   b_sh;
  logic signed [4:0]       dig;

  // operand selection
  logic signed [A_W-1:0] op_a;
  logic signed [B_W-1:0] op_b;
  logic                  op_clr;
  logic [4:0]            ax_off;
  logic [1:0]            ax;
  logic [2:0]            ph;

  assign due      = sample.time_now >= next_due;
  assign accept   = sample.valid && sample.ready;
  assign last_op  = op == OP_LAST;
  assign store_op = (op >= OP_AXIS) && (ph == PH_FINAL);
  // the reading register has to be free before any reading step stores into it
  assign post_fire = (state == ST_POST) && !(store_op && out_valid);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept && due) state_next = ST_LOAD;
      ST_LOAD: state_next = ST_MUL;
      ST_MUL:  if (dcnt == 3'(NUM_DIGITS - 1)) state_next = ST_POST;
      ST_POST: begin
        if (post_fire) state_next = last_op ? ST_IDLE : ST_LOAD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    sample.ready      = state == ST_IDLE;
    reading.valid     = out_valid;
    reading.reading_x = rd[0];
    reading.reading_y = rd[1];
    reading.reading_z = rd[2];
  end

  // axis and phase of the per-axis steps
  always_comb begin
    ax_off = op - OP_AXIS;
    if (ax_off < 5'd5) begin
      ax = 2'd0;
      ph = ax_off[2:0];
    end else if (ax_off < 5'd10) begin
      ax = 2'd1;
      ph = 3'(ax_off - 5'd5);
    end else begin
      ax = 2'd2;
      ph = 3'(ax_off - 5'd10);
    end
  end

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_clr = 1'b0;
    case (op)
      OP_COL0A: begin op_a = A_W'(q_x); op_b = B_W'(q_z); op_clr = 1'b1; end
      OP_COL0B: begin op_a = -A_W'(q_w); op_b = B_W'(q_y); end
      OP_COL1A: begin op_a = A_W'(q_y); op_b = B_W'(q_z); op_clr = 1'b1; end
      OP_COL1B: begin op_a = A_W'(q_w); op_b = B_W'(q_x); end
      OP_COL2A: begin op_a = A_W'(q_w); op_b = B_W'(q_w); op_clr = 1'b1; end
      OP_COL2B: begin op_a = -A_W'(q_x); op_b = B_W'(q_x); end
      OP_COL2C: begin op_a = -A_W'(q_y); op_b = B_W'(q_y); end
      OP_COL2D: begin op_a = A_W'(q_z); op_b = B_W'(q_z); end
      OP_GRAV0: begin op_a = A_W'(gravity); op_b = c20[0]; op_clr = 1'b1; end
      OP_GRAV1: begin op_a = A_W'(gravity); op_b = c20[1]; op_clr = 1'b1; end
      OP_GRAV2: begin op_a = A_W'(gravity); op_b = c20[2]; op_clr = 1'b1; end
      default: begin
        case (ph)
          PH_K0: begin
            op_a = A_W'(body[0]);
            op_b = B_W'(signed'(imu_row[ax][47:32]));
            op_clr = 1'b1;
          end
          PH_K1: begin
            op_a = A_W'(body[1]);
            op_b = B_W'(signed'(imu_row[ax][31:16]));
          end
          PH_K2: begin
            op_a = A_W'(body[2]);
            op_b = B_W'(signed'(imu_row[ax][15:0]));
          end
          PH_NOISE: begin
            op_a = signed'(A_W'(dev_packed[47 - 16 * ax -: 16]));
            op_b = B_W'(noise[ax]);
            op_clr = 1'b1;
          end
          PH_FINAL: begin
            op_a = s_sum;
            op_b = signed'(B_W'(sens_packed[47 - 16 * ax -: 16]));
            op_clr = 1'b1;
          end
          default: ;
        endcase
      end
    endcase
  end

  // one signed radix-16 digit per cycle, the top digit carries the sign
  always_comb begin
    dig     = {(dcnt == 3'(NUM_DIGITS - 1)) ? b_sh[DIGIT_W-1] : 1'b0,
               b_sh[DIGIT_W-1:0]};
    dig_ext = ACC_W'(dig);
    pp      = a_sh * dig_ext;
  end

  // rounded shifts of the accumulator
  logic signed [ACC_W-1:0] rs8x2, rs8, rs20, rs14, rs28;
  logic signed [BODY_W-1:0] gb_cut;
  logic        [15:0]      cnt;

  always_comb begin
    rs8x2  = ((acc <<< 1) + ACC_W'(128)) >>> 8;
    rs8    = (acc + ACC_W'(128)) >>> 8;
    rs20   = (acc + ACC_W'(1 << 19)) >>> 20;
    rs14   = (acc + ACC_W'(1 << 13)) >>> 14;
    rs28   = (acc + ACC_W'(1 << 27)) >>> 28;
    gb_cut = BODY_W'(rs20);
    if (rs28 < 0) begin
      cnt = '0;
    end else if (rs28 > signed'({{(ACC_W - 16){1'b0}}, res})) begin
      cnt = res;
    end else begin
      cnt = rs28[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= '0;
      dcnt      <= '0;
      next_due  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && due) begin
        next_due <= next_due + 32'(PERIOD);
        op       <= OP_COL0A;
      end
      if (state == ST_LOAD) dcnt <= '0;
      if (state == ST_MUL) dcnt <= dcnt + 3'd1;
      if (post_fire && !last_op) op <= op + 5'd1;
      if (reading.valid && reading.ready) out_valid <= 1'b0;
      if (post_fire && last_op) out_valid <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept && due) begin
      q_w       <= sample.quat_w;
      q_x       <= sample.quat_x;
      q_y       <= sample.quat_y;
      q_z       <= sample.quat_z;
      acc_in[0] <= sample.accel_x;
      acc_in[1] <= sample.accel_y;
      acc_in[2] <= sample.accel_z;
      noise[0]  <= sample.noise_x;
      noise[1]  <= sample.noise_y;
      noise[2]  <= sample.noise_z;
    end
    if (state == ST_LOAD) begin
      a_sh <= ACC_W'(op_a);
      b_sh <= op_b;
      if (op_clr) acc <= '0;
    end
    if (state == ST_MUL) begin
      acc  <= acc + pp;
      a_sh <= a_sh <<< DIGIT_W;
      b_sh <= b_sh >>> DIGIT_W;
    end
    if (post_fire) begin
      case (op)
        OP_COL0B: c20[0] <= B_W'(rs8x2);
        OP_COL1B: c20[1] <= B_W'(rs8x2);
        OP_COL2D: c20[2] <= B_W'(rs8);
        OP_GRAV0: body[0] <= BODY_W'(acc_in[0]) - gb_cut;
        OP_GRAV1: body[1] <= BODY_W'(acc_in[1]) - gb_cut;
        OP_GRAV2: body[2] <= BODY_W'(acc_in[2]) - gb_cut;
        default: begin
          if (op >= OP_AXIS) begin
            case (ph)
              PH_K2:    imu <= A_W'(rs14);
              PH_NOISE: s_sum <= A_W'(acc) + (imu <<< 4)
                          + (A_W'(signed'(bias_packed[47 - 16 * ax -: 16])) <<< 12);
              PH_FINAL: rd[ax] <= cnt;
              default: ;
            endcase
          end
        end
      endcase
    end
  end

  // the multiplier never runs past its last digit
  assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |-> dcnt < 3'(NUM_DIGITS))
    else $error("digit counter overran");

  // an early item leaves the due time alone
  assert property (@(posedge clk) disable iff (rst)
    (accept && !due) |=> $stable(next_due))
    else $error("early item moved next_due");

  // a due item moves the due time by one period
  assert property (@(posedge clk) disable iff (rst)
    (accept && due) |=> next_due == $past(next_due) + 32'(PERIOD))
    else $error("next_due not advanced");

  // readings stay inside the configured range
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rd[0] <= res && rd[1] <= res && rd[2] <= res))
    else $error("reading above resolution");

  // the last reading step does not store into a full output register
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_POST && last_op && $past(out_valid) && out_valid) |=> state == ST_POST)
    else $error("result overwrote a waiting reading");

endmodule
`default_nettype wire
